// ===== rtl/software_timer_bank_unit_defines.svh =====
// Assertion macros shared by the timer bank RTL
`ifndef SOFTWARE_TIMER_BANK_UNIT_DEFINES_SVH
`define SOFTWARE_TIMER_BANK_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define STBU_ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define STBU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define STBU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define STBU_ASSERT_HOLDS(lbl, clk, rst, prop, msg)

`define STBU_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`define STBU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/stbu_pkg.sv =====
// Types and constants of the timer bank
`default_nettype none

package stbu_pkg;

   localparam int MODE_W  = 2;
   localparam int IDX_W   = 4;
   localparam int CNT_W   = 32;
   localparam int TIU_W   = 5;
   localparam int RCNT_W  = 5;

   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ARM    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DISARM = 2'd2;

   localparam logic [RCNT_W-1:0] MAX_RESULTS = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/stbu_ram.sv =====
// Generic simple dual-port RAM with registered read
`default_nettype none

module stbu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/software_timer_bank_unit.sv =====
// Top level of the timer bank: item decode, tick scan and result register
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  mode, timer_index, start_count, reload_count
//   rsp      out        rsp_valid/rsp_stall  expired_index, last_expiry
//   csr      in         csr_wr_en            timers_in_use
//
// Arm, disarm and unused modes complete in the cycle they are accepted.
// A tick holds the input while it scans the n timers in use, and through a flush when
// any expires; one remaining-count read port visits a timer a cycle unless results stall.
// Reset clears per-entry valid bits, so no clearing pass is needed.
// A stalled result pauses the scan only when a further expiry must be queued.
`default_nettype none
`include "software_timer_bank_unit_defines.svh"

module software_timer_bank_unit
   import stbu_pkg::*;
#(
   parameter int NUM_TIMERS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [TIU_W-1:0]  csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [MODE_W-1:0] req_mode,
   input  wire logic [IDX_W-1:0]  req_timer_index,
   input  wire logic [CNT_W-1:0]  req_start_count,
   input  wire logic [CNT_W-1:0]  req_reload_count,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [IDX_W-1:0]       rsp_expired_index,
   output logic                   rsp_last_expiry
);

   localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int NW = ($clog2(NUM_TIMERS + 1) > TIU_W) ? $clog2(NUM_TIMERS + 1) : TIU_W;

   state_type state_ff, state_in;
   logic [TIU_W-1:0]      tiu_ff;
   logic [NUM_TIMERS-1:0] vld_ff, vld_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [RCNT_W-1:0]     res_cnt_ff, res_cnt_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;
   logic                  rsp_valid_ff;
   logic [IDX_W-1:0]      rsp_index_ff;
   logic                  rsp_last_ff;

   logic            rem_we, rel_we, rd_en;
   logic [AW-1:0]   rem_wa, rd_addr;
   logic [CNT_W-1:0] rem_wd, rem_rd, rel_rd;

   logic [NW-1:0]   idx_n, tiu_n, num_n, n_act, cur_n;
   logic [AW-1:0]   req_addr;
   logic            req_fire, in_range, is_tick, is_arm, is_disarm;
   logic            cur_vld, armed, expire, take, emit_need, out_free, scan_go, last_k;
   logic [CNT_W-1:0] rem_cur, rel_cur, rem_dec;
   logic            push, push_last;
   logic [IDX_W-1:0] push_idx;

   stbu_ram #(.WIDTH(CNT_W), .DEPTH(NUM_TIMERS)) u_remaining (
      .clock   (clock),
      .wr_en   (rem_we),
      .wr_addr (rem_wa),
      .wr_data (rem_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rem_rd)
   );

   stbu_ram #(.WIDTH(CNT_W), .DEPTH(NUM_TIMERS)) u_reload (
      .clock   (clock),
      .wr_en   (rel_we),
      .wr_addr (req_addr),
      .wr_data (req_reload_count),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rel_rd)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign is_tick   = (req_mode == MODE_TICK);
   assign is_arm    = (req_mode == MODE_ARM);
   assign is_disarm = (req_mode == MODE_DISARM);

   assign idx_n    = NW'(req_timer_index);
   assign tiu_n    = NW'(tiu_ff);
   assign num_n    = NW'(NUM_TIMERS);
   assign n_act    = (tiu_n > num_n) ? num_n : tiu_n;
   assign req_addr = idx_n[AW-1:0];
   assign in_range = (idx_n < n_act);

   assign cur_n     = NW'(idx_ff);
   assign cur_vld   = vld_ff[idx_ff];
   assign rem_cur   = cur_vld ? rem_rd : '0;
   assign rel_cur   = cur_vld ? rel_rd : '0;
   assign armed     = (rem_cur != '0);
   assign rem_dec   = rem_cur - CNT_W'(1);
   assign expire    = armed && (rem_dec == '0);
   assign take      = expire && (res_cnt_ff < MAX_RESULTS);
   assign emit_need = take && pend_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_go   = (state_ff == ST_SCAN) && !(emit_need && !out_free);
   assign last_k    = ((cur_n + NW'(1)) == n_act);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_tick && (n_act != '0)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_go && last_k) begin
               state_in = (pend_ff || take) ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rem_we      = 1'b0;
      rel_we      = 1'b0;
      rem_wa      = idx_ff;
      rem_wd      = '0;
      rd_en       = 1'b0;
      rd_addr     = idx_ff;
      push        = 1'b0;
      push_idx    = pend_idx_ff;
      push_last   = 1'b0;
      idx_in      = idx_ff;
      res_cnt_in  = res_cnt_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      vld_in      = vld_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_arm && in_range) begin
               rem_we           = 1'b1;
               rel_we           = 1'b1;
               rem_wa           = req_addr;
               rem_wd           = req_start_count;
               vld_in[req_addr] = 1'b1;
            end
            if (req_fire && is_disarm && in_range) begin
               rem_we = vld_ff[req_addr];
               rem_wa = req_addr;
            end
            if (req_fire && is_tick && (n_act != '0)) begin
               rd_en      = 1'b1;
               rd_addr    = '0;
               idx_in     = '0;
               res_cnt_in = '0;
               pend_in    = 1'b0;
            end
         end
         ST_SCAN: begin
            if (scan_go) begin
               if (armed) begin
                  rem_we = 1'b1;
                  rem_wd = expire ? rel_cur : rem_dec;
               end
               if (emit_need) begin
                  push = 1'b1;
               end
               if (take) begin
                  pend_in     = 1'b1;
                  pend_idx_in = cur_n[IDX_W-1:0];
                  res_cnt_in  = res_cnt_ff + RCNT_W'(1);
               end
               if (!last_k) begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + AW'(1);
                  idx_in  = idx_ff + AW'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               pend_in   = 1'b0;
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tiu_ff       <= '0;
         vld_ff       <= '0;
         pend_ff      <= 1'b0;
         res_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vld_ff     <= vld_in;
         pend_ff    <= pend_in;
         res_cnt_ff <= res_cnt_in;
         if (csr_wr_en) begin
            tiu_ff <= csr_wr_data;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
      if (push) begin
         rsp_index_ff <= push_idx;
         rsp_last_ff  <= push_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_expired_index = rsp_index_ff;
   assign rsp_last_expiry   = rsp_last_ff;

   `STBU_ASSERT_IMPLY(a_push_free, clock, reset, push, out_free, "result pushed over a held item")
   `STBU_ASSERT_IMPLY(a_flush_pend, clock, reset, state_ff == ST_FLUSH, pend_ff, "flush without pending item")
   `STBU_ASSERT_HOLDS(a_cnt_cap, clock, reset, res_cnt_ff <= MAX_RESULTS, "result count beyond cap")
   `STBU_ASSERT_NEXT(a_last_idle, clock, reset, push && push_last, state_ff == ST_IDLE, "scan still busy after last item")

endmodule

`default_nettype wire
